FILE: src/sst_pkg.sv
package sst_pkg;

  localparam int DEPTH   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_CMP,
    ST_AUX_RD,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    value_t            wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic   load;
    value_t value;
    logic   last;
    logic   ovf;
  } beat_t;

endpackage

FILE: src/stack_sort_with_auxiliary_stack.sv
// channel  direction  tdata          tlast       tuser
// s_axis   in         value[31:0]    final_item  -
// m_axis   out        sorted_value   run_end     overflowed
//
// loading takes one beat per cycle while idle
// sorting pops each element off the main stack, first moving smaller aux tops
// back onto main, then pushes it onto aux; output then reads aux from the bottom
// input is not ready from the final beat until the last result is loaded
// an output stall holds the result register and pauses the emit sequence
// synchronous reset empties both stacks at once, no clearing pass
module stack_sort_with_auxiliary_stack
  import sst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value[31:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // sorted_value[31:0]
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // overflowed
);

  ram_req_t main_req, aux_req;
  value_t   main_rdata, aux_rdata;
  beat_t    beat;
  logic     out_free;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  sst_sorter u_sorter (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_value   (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .out_free   (out_free),
    .beat       (beat),
    .main_req   (main_req),
    .main_rdata (main_rdata),
    .aux_req    (aux_req),
    .aux_rdata  (aux_rdata)
  );

  sst_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_main_ram (
    .clk   (clk),
    .we    (main_req.we),
    .waddr (main_req.waddr),
    .wdata (main_req.wdata),
    .re    (main_req.re),
    .raddr (main_req.raddr),
    .rdata (main_rdata)
  );

  sst_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_aux_ram (
    .clk   (clk),
    .we    (aux_req.we),
    .waddr (aux_req.waddr),
    .wdata (aux_req.wdata),
    .re    (aux_req.re),
    .raddr (aux_req.raddr),
    .rdata (aux_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (beat.load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat.load) begin
      m_axis_tdata <= beat.value;
      m_axis_tlast <= beat.last;
      m_axis_tuser <= beat.ovf;
    end
  end

endmodule

FILE: src/sst_ram.sv
module sst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/sst_sorter.sv
module sst_sorter
  import sst_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  value_t   in_value,
  input  logic     in_last,
  input  logic     out_free,
  output beat_t    beat,
  output ram_req_t main_req,
  input  value_t   main_rdata,
  output ram_req_t aux_req,
  input  value_t   aux_rdata
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  n, n_next;
  logic [CNT_W-1:0]  an, an_next;
  logic [ADDR_W-1:0] k, k_next;
  logic              ovf, ovf_next;
  value_t            aux_top, aux_top_next;

  logic [CNT_W-1:0] n_dec;
  logic [CNT_W-1:0] an_dec2;
  logic [CNT_W-1:0] k_inc;

  assign n_dec   = n - CNT_W'(1);
  assign an_dec2 = an - CNT_W'(2);
  assign k_inc   = CNT_W'(k) + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      n     <= '0;
      an    <= '0;
      k     <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      n     <= n_next;
      an    <= an_next;
      k     <= k_next;
      ovf   <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    aux_top <= aux_top_next;
  end

  always_comb begin
    state_next   = state;
    n_next       = n;
    an_next      = an;
    k_next       = k;
    ovf_next     = ovf;
    aux_top_next = aux_top;
    main_req     = '0;
    aux_req      = '0;
    beat         = '0;
    in_ready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (n < CNT_W'(DEPTH)) begin
            main_req.we    = 1'b1;
            main_req.waddr = n[ADDR_W-1:0];
            main_req.wdata = in_value;
            n_next         = n + CNT_W'(1);
          end else begin
            ovf_next = 1'b1;
          end
          if (in_last) begin
            state_next = ST_POP;
          end
        end
      end
      ST_POP: begin
        if (n == '0) begin
          k_next     = '0;
          state_next = ST_EMIT_RD;
        end else begin
          main_req.re    = 1'b1;
          main_req.raddr = n_dec[ADDR_W-1:0];
          n_next         = n_dec;
          state_next     = ST_CMP;
        end
      end
      ST_CMP: begin
        if (an != '0 && aux_top < main_rdata) begin
          // smaller aux top goes back onto main
          main_req.we    = 1'b1;
          main_req.waddr = n[ADDR_W-1:0];
          main_req.wdata = aux_top;
          n_next         = n + CNT_W'(1);
          an_next        = an - CNT_W'(1);
          aux_req.re     = 1'b1;
          aux_req.raddr  = an_dec2[ADDR_W-1:0];
          state_next     = ST_AUX_RD;
        end else begin
          aux_req.we     = 1'b1;
          aux_req.waddr  = an[ADDR_W-1:0];
          aux_req.wdata  = main_rdata;
          aux_top_next   = main_rdata;
          an_next        = an + CNT_W'(1);
          state_next     = ST_POP;
        end
      end
      ST_AUX_RD: begin
        aux_top_next = aux_rdata;
        state_next   = ST_CMP;
      end
      ST_EMIT_RD: begin
        // aux bottom holds the largest value
        if (out_free) begin
          aux_req.re    = 1'b1;
          aux_req.raddr = k;
          state_next    = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        beat.load  = 1'b1;
        beat.value = aux_rdata;
        beat.last  = (k_inc == an);
        beat.ovf   = ovf;
        if (k_inc == an) begin
          an_next    = '0;
          ovf_next   = 1'b0;
          k_next     = '0;
          state_next = ST_IDLE;
        end else begin
          k_next     = k + ADDR_W'(1);
          state_next = ST_EMIT_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    (CNT_W+1)'(n) + (CNT_W+1)'(an) <= (CNT_W+1)'(DEPTH))
    else $error("stack contents exceed capacity");

  a_beat_slot: assert property (@(posedge clk) disable iff (rst)
    beat.load |-> $past(out_free))
    else $error("beat loaded while output register busy");

  a_run_done: assert property (@(posedge clk) disable iff (rst)
    (beat.load && beat.last) |=> (state == ST_IDLE && n == '0 && an == '0 && !ovf))
    else $error("run did not return to empty idle");

  a_aux_push: assert property (@(posedge clk) disable iff (rst)
    aux_req.we |-> (an < CNT_W'(DEPTH) && state == ST_CMP))
    else $error("aux push beyond capacity");

endmodule

FILE: dv/stack_sort_checker.sv
`timescale 1ns / 100ps
module stack_sort_checker
  import sst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value[31:0]
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // sorted_value[31:0]
  input  logic        m_axis_tlast,
  input  logic        m_axis_tuser,   // overflowed
  output int          mismatches,
  output int          outstanding
);

  typedef struct {
    value_t sorted_value;
    logic   run_end;
    logic   overflowed;
  } sorted_beat_t;

  value_t       stacked[$];
  logic         dropped_push = 1'b0;
  sorted_beat_t sorted_due[$];
  int           fail_count = 0;

  task automatic take_value(input value_t v, input logic fin);
    value_t ordered[$];
    int     pos;
    if (stacked.size() < DEPTH) begin
      stacked.push_back(v);
    end else begin
      dropped_push = 1'b1;
    end
    if (fin) begin
      // insertion sort, largest first
      foreach (stacked[i]) begin
        pos = 0;
        while (pos < ordered.size() && ordered[pos] >= stacked[i]) pos++;
        ordered.insert(pos, stacked[i]);
      end
      foreach (ordered[i]) begin
        sorted_due.push_back('{ordered[i], i == ordered.size() - 1, dropped_push});
      end
      stacked.delete();
      dropped_push = 1'b0;
    end
  endtask

  task automatic check_result(input value_t v, input logic last, input logic ovf);
    sorted_beat_t want;
    if (sorted_due.size() == 0) begin
      $display("%0t: unexpected beat, expected none, got value %0d tlast %b tuser %b",
               $time, v, last, ovf);
      fail_count++;
    end else begin
      want = sorted_due.pop_front();
      if (v !== want.sorted_value) begin
        $display("%0t: sorted_value expected %0d got %0d", $time, want.sorted_value, v);
        fail_count++;
      end
      if (last !== want.run_end) begin
        $display("%0t: run_end expected %b got %b", $time, want.run_end, last);
        fail_count++;
      end
      if (ovf !== want.overflowed) begin
        $display("%0t: overflowed expected %b got %b", $time, want.overflowed, ovf);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      stacked.delete();
      sorted_due.delete();
      dropped_push = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) take_value(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
    mismatches  <= fail_count;
    outstanding <= sorted_due.size();
  end

endmodule

FILE: dv/tb_stack_sort_with_auxiliary_stack.sv
`timescale 1ns / 100ps
module tb_stack_sort_with_auxiliary_stack
  import sst_pkg::*;
();

  localparam value_t MAX_VALUE = 32'sh7FFF_FFFF;
  localparam value_t MIN_VALUE = 32'sh8000_0000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        calm = 1'b0;
  int          mismatches;
  int          outstanding;
  int          accepted = 0;

  always #4 clk = ~clk;

  stack_sort_with_auxiliary_stack u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  stack_sort_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  always @(posedge clk) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 29);
  end

  task automatic send_beat(input value_t v, input logic fin);
    while (!calm && $urandom_range(0, 99) < 29) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
    accepted++;
  endtask

  task automatic send_run_of(input value_t vals[$]);
    foreach (vals[i]) send_beat(vals[i], i == vals.size() - 1);
  endtask

  function automatic value_t pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom;
    // narrow range so equal values show up often
    if (r < 8) return $signed($urandom_range(0, 8)) - 4;
    case ($urandom_range(0, 3))
      0: return MAX_VALUE;
      1: return MIN_VALUE;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  task automatic send_run(input int len);
    for (int k = 0; k < len; k++) send_beat(pick_value(), k == len - 1);
  endtask

  initial begin
    int r;
    int len;
    int runs;
    runs = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_run_of('{MAX_VALUE});
    send_run_of('{MIN_VALUE});
    send_run_of('{0, -1, 1, MAX_VALUE, MIN_VALUE, -1, 5, 5, 0});
    send_run_of('{1, 2, 3, 4});
    send_run_of('{4, 3, 2, 1});
    send_run_of('{3, 3});

    while (accepted < 420) begin
      calm <= (accepted >= 180 && accepted < 280);
      r = $urandom_range(0, 99);
      // exactly full first, then a run that overflows and ends on a full stack
      if (runs == 0) len = DEPTH;
      else if (runs == 1) len = DEPTH + 3;
      else if (r < 70) len = $urandom_range(1, 10);
      else if (r < 80) len = $urandom_range(11, DEPTH - 1);
      else if (r < 88) len = DEPTH;
      else len = $urandom_range(DEPTH + 1, DEPTH + 6);
      send_run(len);
      runs++;
    end
    s_axis_tvalid <= 1'b0;
    calm <= 1'b0;

    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
